[rtl/core/fbpa_pkg.sv]
// Shared widths, codes and interface types of the fixed block pool allocator.
package fbpa_pkg;

	localparam int CNT_W      = 11;
	localparam int BYTES_W    = 16;
	localparam int RND_W      = BYTES_W + 1;
	localparam int OFF_W      = 27;
	localparam int IN_IDX_W   = 10;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 16;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 48;
	localparam int M_TUSER_W  = 2;

	localparam int DEF_MAX_BLOCKS = 1024;
	localparam int DEF_WORD_BYTES = 8;

	localparam logic [CNT_W-1:0]   RST_BLOCK_COUNT = 11'd1024;
	localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = 16'd8;
	localparam logic [CNT_W-1:0]   COUNT_SAT       = 11'h7FF;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'b1;

	typedef struct packed {
		logic                en;
		logic [OP_W-1:0]     op;
		logic [IN_IDX_W-1:0] index;
		logic [CNT_W-1:0]    pool_n;
	} fl_cmd_t;

	typedef struct packed {
		logic             granted;
		logic             bad;
		logic [CNT_W-1:0] free_count;
	} fl_rsp_t;

endpackage

[rtl/core/fbpa_free_list.sv]
// Free list of the block pool: freed-block stack with link memory, fresh mark and free count.
module fbpa_free_list #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
	localparam int IDX_W = $clog2(MAX_BLOCKS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fbpa_pkg::fl_cmd_t cmd,
	output fbpa_pkg::fl_rsp_t rsp,
	output logic [IDX_W-1:0]  grant_idx
);
	import fbpa_pkg::*;

	localparam int ENT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] RST_TOTAL = (int'(RST_BLOCK_COUNT) > MAX_BLOCKS) ?
		CNT_W'(MAX_BLOCKS) : RST_BLOCK_COUNT;

	// Each entry holds the valid flag of the link in its top bit and the index below it.
	logic [ENT_W-1:0] mem [MAX_BLOCKS];
	logic [ENT_W-1:0] rd_q;
	logic [ENT_W-1:0] byp_q;
	logic             sel_q;
	logic             stack_v_q;
	logic [IDX_W-1:0] top_q;
	logic [CNT_W-1:0] mark_q;
	logic [CNT_W-1:0] total_q;

	logic [ENT_W-1:0]          link;
	logic [IDX_W+CNT_W-1:0]    mark_ext;
	logic [IDX_W+IN_IDX_W-1:0] req_ext;
	logic [IDX_W-1:0]          mark_idx;
	logic [IDX_W-1:0]          req_idx;
	logic                      pop;
	logic                      take_new;
	logic                      push;
	logic                      clr;
	logic                      bad;
	logic [CNT_W-1:0]          total_nx;

	// The link below the top is either the entry read at the last pop or the old top saved at
	// the last push, so the next pop never waits on the memory.
	assign link     = sel_q ? rd_q : byp_q;
	assign mark_ext = {{IDX_W{1'b0}}, mark_q};
	assign req_ext  = {{IDX_W{1'b0}}, cmd.index};
	assign mark_idx = mark_ext[IDX_W-1:0];
	assign req_idx  = req_ext[IDX_W-1:0];

	always_comb begin
		pop      = 1'b0;
		take_new = 1'b0;
		push     = 1'b0;
		clr      = 1'b0;
		bad      = 1'b0;
		if (cmd.en) begin
			unique case (cmd.op)
				OP_ALLOC: begin
					if (stack_v_q) begin
						pop = 1'b1;
					end else if (mark_q < cmd.pool_n) begin
						take_new = 1'b1;
					end
				end
				OP_FREE: begin
					if ({1'b0, cmd.index} >= cmd.pool_n) begin
						bad = 1'b1;
					end else begin
						push = 1'b1;
					end
				end
				OP_CLEAR: begin
					clr = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		total_nx = total_q;
		priority if (clr) begin
			total_nx = cmd.pool_n;
		end else if (pop || take_new) begin
			if (total_q != '0) begin
				total_nx = total_q - CNT_W'(1);
			end
		end else if (push) begin
			if (total_q != COUNT_SAT) begin
				total_nx = total_q + CNT_W'(1);
			end
		end
	end

	assign grant_idx      = pop ? top_q : mark_idx;
	assign rsp.granted    = pop || take_new;
	assign rsp.bad        = bad;
	assign rsp.free_count = total_nx;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[req_idx] <= {stack_v_q, top_q};
		end
		if (pop) begin
			rd_q <= mem[link[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			top_q <= link[IDX_W-1:0];
		end else if (push) begin
			top_q <= req_idx;
			byp_q <= {stack_v_q, top_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_v_q <= 1'b0;
			sel_q     <= 1'b0;
			mark_q    <= '0;
			total_q   <= RST_TOTAL;
		end else begin
			if (pop) begin
				stack_v_q <= link[IDX_W];
				sel_q     <= 1'b1;
			end else if (push) begin
				stack_v_q <= 1'b1;
				sel_q     <= 1'b0;
			end else if (clr) begin
				stack_v_q <= 1'b0;
			end
			if (take_new) begin
				mark_q <= mark_q + CNT_W'(1);
			end else if (clr) begin
				mark_q <= '0;
			end
			if (cmd.en) begin
				total_q <= total_nx;
			end
		end
	end

endmodule

[rtl/core/fixed_block_pool_allocator_unit.sv]
// Top level of the fixed block pool allocator: stream ports, configuration and offset math.
//
//  Channel  Direction  Beat content (lowest bit first)
//  s_axis   in         tdata: block_index; tuser: opcode
//  m_axis   out        tdata: granted_index, granted_offset, free_count;
//                      tuser: granted, bad_request
//  cfg      in         write enable, register index, write data (no read-back)
//
// One request beat is taken every cycle unless a low m_axis_tready holds the result register.
// Its result beat passes the input register and the result register before m_axis shows it.
// The pace is set by the free list update, which completes in the cycle a request leaves the
// input register; the link memory read for the following pop is issued at that same edge.
// Reset empties the freed-block stack and sets the free count to the pool size; the link
// memory is not cleared, since every entry is written before it is followed.
// When the result register is held by a low m_axis_tready, the input register holds too,
// and s_axis_tready stays high only while the input register is empty.
module fixed_block_pool_allocator_unit #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
	parameter int WORD_BYTES = fbpa_pkg::DEF_WORD_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// block_index [9:0], zero fill above
	input  logic [fbpa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// opcode [1:0]
	input  logic [fbpa_pkg::S_TUSER_W-1:0]    s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// granted_index [9:0], granted_offset [36:10], free_count [47:37]
	output logic [fbpa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// granted [0], bad_request [1]
	output logic [fbpa_pkg::M_TUSER_W-1:0]    m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fbpa_pkg::*;

	localparam int IDX_W = $clog2(MAX_BLOCKS);

	// Rounding the block size up to whole words divides by the word size through a reciprocal.
	// With a 17-bit dividend and a word of at most 16 bytes, a 22-bit shift makes the quotient
	// exact without a correction step.
	localparam int RECIP_SH = 22;
	localparam int RECIP    = ((1 << RECIP_SH) + WORD_BYTES - 1) / WORD_BYTES;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int PROD_W   = RND_W + RECIP_W;
	localparam logic [RND_W-1:0] RST_RND =
		RND_W'(((int'(RST_BLOCK_BYTES) + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES);

	// Configuration registers. Only the rounded block size is kept, since offsets need nothing else.
	logic [CNT_W-1:0]  blk_cnt_q;
	logic [RND_W-1:0]  rnd_q;
	logic [RND_W-1:0]  bytes_up;
	logic [PROD_W-1:0] recip_prod;
	logic [RND_W-1:0]  words;
	logic [RND_W-1:0]  rnd_nx;

	assign bytes_up   = RND_W'(cfg_data) + RND_W'(WORD_BYTES - 1);
	assign recip_prod = PROD_W'(bytes_up) * PROD_W'(RECIP);
	assign words      = recip_prod[RECIP_SH +: RND_W];
	// The word size is a small constant, so this product is a couple of shifted adds.
	assign rnd_nx     = words * RND_W'(WORD_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_cnt_q <= RST_BLOCK_COUNT;
			rnd_q     <= RST_RND;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_COUNT: blk_cnt_q <= cfg_data[CNT_W-1:0];
				REG_BLOCK_BYTES: rnd_q     <= rnd_nx;
				default: begin
				end
			endcase
		end
	end

	// Input register.
	logic                v_s1;
	logic [OP_W-1:0]     op_s1;
	logic [IN_IDX_W-1:0] idx_s1;
	logic                adv;

	// Result register.
	logic                v_s2;
	logic [IN_IDX_W-1:0] gidx_s2;
	logic [OFF_W-1:0]    off_s2;
	logic                granted_s2;
	logic                bad_s2;
	logic [CNT_W-1:0]    fc_s2;

	assign adv           = !v_s2 || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1  <= s_axis_tuser[OP_W-1:0];
			idx_s1 <= s_axis_tdata[IN_IDX_W-1:0];
		end
	end

	// Pool size seen by the free list: the block count, capped at the pool capacity.
	logic [CNT_W-1:0] pool_n;
	fl_cmd_t          cmd;
	fl_rsp_t          rsp;
	logic [IDX_W-1:0] grant_idx;

	assign pool_n = (int'(blk_cnt_q) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : blk_cnt_q;

	always_comb begin
		cmd.en     = v_s1 && adv;
		cmd.op     = op_s1;
		cmd.index  = idx_s1;
		cmd.pool_n = pool_n;
	end

	fbpa_free_list #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_free_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rsp      (rsp),
		.grant_idx(grant_idx)
	);

	// Byte offset: one header word plus the index times the rounded block size, kept to the
	// width of the offset field.
	logic [IDX_W+IN_IDX_W-1:0] gidx_ext;
	logic [IN_IDX_W-1:0]       gidx_out;
	logic [OFF_W-1:0]          g_off;

	assign gidx_ext = {{IN_IDX_W{1'b0}}, grant_idx};
	assign gidx_out = gidx_ext[IN_IDX_W-1:0];
	assign g_off    = OFF_W'(grant_idx) * OFF_W'(rnd_q) + OFF_W'(WORD_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			gidx_s2    <= rsp.granted ? gidx_out : '0;
			off_s2     <= rsp.granted ? g_off : '0;
			granted_s2 <= rsp.granted;
			bad_s2     <= rsp.bad;
			fc_s2      <= rsp.free_count;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {fc_s2, off_s2, gidx_s2};
	assign m_axis_tuser  = {bad_s2, granted_s2};

`ifndef SYNTHESIS
	// A result never both grants a block and reports a bad free.
	a_grant_excludes_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("result both granted and bad");

	// Without a grant, the index and offset fields are zero.
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[36:0] == '0))
		else $error("ungranted result carries an index or offset");

	// A request held back by a full result register stays in the input register unchanged.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(op_s1) && $stable(idx_s1)))
		else $error("input register changed while stalled");
`endif

endmodule
